// File: rtl/core/rsmk_pkg.sv
// Shared types, codes and helpers for the record sort core.
`default_nettype none

package rsmk_pkg;

  localparam int IdW    = 30;
  localparam int NameW  = 64;
  localparam int ScoreW = 8;
  localparam int TotalW = 10;
  localparam int AvgW   = 8;
  localparam int PosW   = 6;
  localparam int InDataW  = 184;
  localparam int OutDataW = 208;

  // Reciprocal of three in 11 fraction bits; exact floor for totals up to 765.
  localparam logic [10:0] RecipThree = 11'd683;

  typedef struct packed {
    logic [ScoreW-1:0] score_c;
    logic [ScoreW-1:0] score_b;
    logic [ScoreW-1:0] score_a;
    logic [NameW-1:0]  name_tail;
    logic [NameW-1:0]  name_head;
    logic [IdW-1:0]    student_id;
  } rec_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ID    = 2'd1,
    MODE_NAME  = 2'd2,
    MODE_TOTAL = 2'd3
  } sort_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV_LD,
    ST_SWEEP,
    ST_WB,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_t;

  function automatic logic [TotalW-1:0] score_sum(rec_t r);
    return TotalW'(r.score_a) + TotalW'(r.score_b) + TotalW'(r.score_c);
  endfunction

  function automatic logic [AvgW-1:0] div_three(logic [TotalW-1:0] tot);
    logic [20:0] prod;
    prod = 21'(tot) * 21'(RecipThree);
    return prod[18:11];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rsmk_rec_mem.sv
// Record store: one write port, one registered read port.
`default_nettype none

module rsmk_rec_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire rsmk_pkg::rec_t   wdata,
  input  wire logic [AW-1:0]    raddr,
  output rsmk_pkg::rec_t        rdata
);
  import rsmk_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/rsmk_order.sv
// Key compare: flags when the held record must move behind the fetched one.
`default_nettype none

module rsmk_order (
  input  wire rsmk_pkg::sort_mode_t mode,
  input  wire rsmk_pkg::rec_t       rec_a,
  input  wire rsmk_pkg::rec_t       rec_b,
  output logic                      swap
);
  import rsmk_pkg::*;

  logic [TotalW-1:0] total_a;
  logic [TotalW-1:0] total_b;

  assign total_a = score_sum(rec_a);
  assign total_b = score_sum(rec_b);

  always_comb begin
    case (mode)
      MODE_ID:    swap = rec_a.student_id > rec_b.student_id;
      // head then tail as one big-endian number
      MODE_NAME:  swap = {rec_a.name_head, rec_a.name_tail} >
                         {rec_b.name_head, rec_b.name_tail};
      MODE_TOTAL: swap = total_a < total_b;
      default:    swap = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/record_sort_multi_key_core.sv
// Top level: record load, in-memory exchange sort and result emission.
`default_nettype none

// Collects up to CAPACITY records, one word per cycle, into a single-port-
// read record memory; words past capacity are dropped. The word with tlast
// starts the sort (unless the mode is "keep order" or fewer than two records
// are held), which fixes one position at a time: the record at that position
// sits in a pivot register while the later entries are read one per cycle
// and swapped through the memory's write port. Each result word is then read
// from the memory, registered and offered until m_axis_tready takes it. No
// input word is taken from the tlast word until the final result word has
// been delivered. sort_mode must be written only while the block is idle.
module record_sort_multi_key_core #(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_wdata,  // sort_mode
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // student_id, name_head, name_tail, score_a, score_b, score_c, zero pad
  input  wire logic [rsmk_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic                           s_axis_tlast,  // load_last
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // position, out_id, out_name_head, out_name_tail, out_score_a,
  // out_score_b, out_score_c, score_total, score_average, zero pad
  output logic [rsmk_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast   // emit_last
);
  import rsmk_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [NameW-1:0] TailMask = ~({NameW{1'b1}} >> ((NAME_BYTES - 8) * 8));

  state_t            state;
  state_t            state_next;
  sort_mode_t        mode;
  logic [CW-1:0]     count;
  logic [CW-1:0]     n_rec;
  logic [CW-1:0]     n_new;
  logic [AW-1:0]     i_idx;
  logic [AW-1:0]     j_idx;
  logic [AW-1:0]     k_idx;
  rec_t              pivot;
  rec_t              in_rec;
  rec_t              rdata;
  rec_t              wdata;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              swap;
  logic              in_fire;
  logic              out_fire;
  logic              has_room;
  logic              sweep_end;
  logic              more_pivots;
  logic              start_sort;

  rec_t              out_rec;
  logic [PosW-1:0]   out_pos;
  logic [TotalW-1:0] out_total;
  logic [AvgW-1:0]   out_avg;
  logic              out_last;
  logic [TotalW-1:0] rd_total;

  assign in_rec.student_id = s_axis_tdata[29:0];
  assign in_rec.name_head  = s_axis_tdata[93:30];
  assign in_rec.name_tail  = s_axis_tdata[157:94] & TailMask;
  assign in_rec.score_a    = s_axis_tdata[165:158];
  assign in_rec.score_b    = s_axis_tdata[173:166];
  assign in_rec.score_c    = s_axis_tdata[181:174];

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_fire    = m_axis_tvalid && m_axis_tready;
  assign has_room    = count < CW'(CAPACITY);
  assign n_new       = has_room ? count + CW'(1) : count;
  assign start_sort  = (mode != MODE_NONE) && (n_new >= CW'(2));
  assign sweep_end   = (CW'(j_idx) + CW'(1)) == n_rec;
  assign more_pivots = (CW'(i_idx) + CW'(2)) < n_rec;
  assign rd_total    = score_sum(rdata);

  rsmk_rec_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rsmk_order u_order (
    .mode  (mode),
    .rec_a (pivot),
    .rec_b (rdata),
    .swap  (swap)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_next = start_sort ? ST_PIV_RD : ST_EMIT_RD;
        end
      end
      ST_PIV_RD:  state_next = ST_PIV_LD;
      ST_PIV_LD:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_end) begin
          state_next = ST_WB;
        end
      end
      ST_WB:      state_next = more_pivots ? ST_PIV_LD : ST_EMIT_RD;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_fire) begin
          state_next = out_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    mem_we        = 1'b0;
    waddr         = count[AW-1:0];
    wdata         = in_rec;
    raddr         = i_idx;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_we        = in_fire && has_room;
      end
      ST_PIV_RD:  raddr = i_idx;
      ST_PIV_LD:  raddr = i_idx + AW'(1);
      ST_SWEEP: begin
        raddr  = j_idx + AW'(1);
        mem_we = swap;
        waddr  = j_idx;
        wdata  = pivot;
      end
      ST_WB: begin
        raddr  = i_idx + AW'(1);
        mem_we = 1'b1;
        waddr  = i_idx;
        wdata  = pivot;
      end
      ST_EMIT_RD:  raddr = k_idx;
      ST_EMIT_LD:  raddr = k_idx;
      ST_EMIT_OUT: m_axis_tvalid = 1'b1;
      default:     raddr = i_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= MODE_NONE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        mode <= sort_mode_t'(cfg_wdata);
      end
      if (state == ST_IDLE && in_fire) begin
        count <= n_new;
      end else if (state == ST_EMIT_OUT && out_fire && out_last) begin
        count <= '0;
      end
    end
  end

  // sort and emission datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n_rec <= n_new;
        i_idx <= '0;
        k_idx <= '0;
      end
      ST_PIV_LD: begin
        pivot <= rdata;
        j_idx <= i_idx + AW'(1);
      end
      ST_SWEEP: begin
        // keep the better record in the pivot, push the other back
        if (swap) begin
          pivot <= rdata;
        end
        j_idx <= j_idx + AW'(1);
      end
      ST_WB:      i_idx <= i_idx + AW'(1);
      ST_EMIT_LD: begin
        out_rec   <= rdata;
        out_pos   <= PosW'(k_idx);
        out_total <= rd_total;
        out_avg   <= div_three(rd_total);
        out_last  <= (CW'(k_idx) + CW'(1)) == n_rec;
      end
      ST_EMIT_OUT: begin
        if (out_fire) begin
          k_idx <= k_idx + AW'(1);
        end
      end
      default: begin
        pivot <= pivot;
      end
    endcase
  end

  assign m_axis_tdata = {2'b00, out_avg, out_total, out_rec.score_c, out_rec.score_b,
                         out_rec.score_a, out_rec.name_tail, out_rec.name_head,
                         out_rec.student_id, out_pos};
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result word is pending");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_axis_tlast |=> s_axis_tready && count == '0)
    else $error("block not idle and empty after the final result word");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> CW'(k_idx) < n_rec)
    else $error("result position beyond the held set");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the record sort core: load, sort by each key, emit.
`timescale 1ns / 1ps

module tb_top;
  import rsmk_pkg::*;

  localparam int Capacity = 64;

  // Result word layout, lowest field last in the declaration.
  typedef struct packed {
    logic [1:0]        pad;
    logic [AvgW-1:0]   avg;
    logic [TotalW-1:0] total;
    logic [ScoreW-1:0] score_c;
    logic [ScoreW-1:0] score_b;
    logic [ScoreW-1:0] score_a;
    logic [NameW-1:0]  name_tail;
    logic [NameW-1:0]  name_head;
    logic [IdW-1:0]    student_id;
    logic [PosW-1:0]   position;
  } out_word_t;

  typedef struct {
    out_word_t w;
    bit        last;
  } ranked_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  record_sort_multi_key_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Roster model: held records, their count and the active sort key.
  rec_t          roster[Capacity];
  int            roster_count;
  sort_mode_t    active_key;
  ranked_row_t   ranked_rows[$];
  int            fail_count;
  int            src_gap_max;
  int            sink_gap_max;
  logic [127:0]  name_pool[4];

  always #5 clk = ~clk;

  function automatic int record_total(rec_t r);
    return int'(r.score_a) + int'(r.score_b) + int'(r.score_c);
  endfunction

  function automatic bit ranks_behind(rec_t a, rec_t b);
    case (active_key)
      MODE_ID:    return a.student_id > b.student_id;
      MODE_NAME:  return {a.name_head, a.name_tail} > {b.name_head, b.name_tail};
      MODE_TOTAL: return record_total(a) < record_total(b);
      default:    return 1'b0;
    endcase
  endfunction

  function automatic rec_t mk_rec(int unsigned id, logic [63:0] head, logic [63:0] tail,
                                  int a, int b, int c);
    rec_t r;
    r.student_id = id[IdW-1:0];
    r.name_head  = head;
    r.name_tail  = tail;
    r.score_a    = a[7:0];
    r.score_b    = b[7:0];
    r.score_c    = c[7:0];
    return r;
  endfunction

  // Store the record if there is room; on the last word sort and queue the ranking.
  task automatic take_record(rec_t r, bit last);
    rec_t        tmp;
    ranked_row_t row;
    int          tot;
    if (roster_count < Capacity) begin
      roster[roster_count] = r;
      roster_count++;
    end
    if (last) begin
      for (int i = 0; i + 1 < roster_count; i++)
        for (int j = i + 1; j < roster_count; j++)
          if (ranks_behind(roster[i], roster[j])) begin
            tmp = roster[i];
            roster[i] = roster[j];
            roster[j] = tmp;
          end
      for (int i = 0; i < roster_count; i++) begin
        tot              = record_total(roster[i]);
        row.w            = '0;
        row.w.position   = i[PosW-1:0];
        row.w.student_id = roster[i].student_id;
        row.w.name_head  = roster[i].name_head;
        row.w.name_tail  = roster[i].name_tail;
        row.w.score_a    = roster[i].score_a;
        row.w.score_b    = roster[i].score_b;
        row.w.score_c    = roster[i].score_c;
        row.w.total      = tot[TotalW-1:0];
        row.w.avg        = 8'(tot / 3);
        row.last         = (i + 1 == roster_count);
        ranked_rows.push_back(row);
      end
      roster_count = 0;
    end
  endtask

  task automatic send_record(rec_t r, bit last);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    repeat (gap) @(negedge clk);
    s_axis_tdata  = {2'b00, r};
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    take_record(r, last);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (ranked_rows.size() != 0) @(negedge clk);
    // let the core settle back to idle after the final word
    repeat (8) @(negedge clk);
  endtask

  task automatic set_sort_mode(sort_mode_t m);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we    = 1'b0;
    active_key = m;
  endtask

  function automatic logic [127:0] make_name(int len);
    logic [127:0] s;
    s = '0;
    for (int k = 0; k < len; k++)
      s[127 - 8 * k -: 8] = 8'($urandom_range(122, 97));
    return s;
  endfunction

  function automatic rec_t rand_record();
    rec_t         r;
    logic [127:0] nm;
    int           pick;
    pick = $urandom_range(5, 0);
    if (pick < 2) nm = name_pool[$urandom_range(3, 0)];
    else if (pick < 4) nm = make_name($urandom_range(16, 0));
    else nm = {$urandom, $urandom, $urandom, $urandom};
    r.name_head  = nm[127:64];
    r.name_tail  = nm[63:0];
    r.student_id = ($urandom_range(3, 0) == 0) ? IdW'($urandom_range(4, 0))
                                               : IdW'($urandom_range(999999999, 0));
    r.score_a = ($urandom_range(7, 0) == 0) ? 8'hFF : 8'($urandom_range(255, 0));
    r.score_b = ($urandom_range(7, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 0));
    r.score_c = 8'($urandom_range(255, 0));
    return r;
  endfunction

  task automatic test_keep_order();
    src_gap_max  = 0;
    sink_gap_max = 0;
    // reset value of the key is keep-order
    send_record(mk_rec(0, '0, '0, 0, 0, 0), 1'b0);
    send_record(mk_rec(999999999, '1, '1, 255, 255, 255), 1'b1);
    set_sort_mode(MODE_NONE);
    send_record(mk_rec(536870912, 64'h8000_0000_0000_0000, '1, 1, 1, 2), 1'b1);
  endtask

  task automatic test_each_key();
    rec_t tie_set[6];
    sort_mode_t keys[3];
    logic [63:0] bob;
    bob = 64'h626F_6200_0000_0000;
    // ties on every key, so swap order decides the ranking
    tie_set[0] = mk_rec(7, bob, '0, 10, 20, 30);
    tie_set[1] = mk_rec(999999999, '1, '1, 255, 255, 255);
    tie_set[2] = mk_rec(7, bob, 64'h1, 30, 20, 10);
    tie_set[3] = mk_rec(0, '0, '0, 0, 0, 0);
    tie_set[4] = mk_rec(3, bob, '0, 60, 0, 0);
    tie_set[5] = mk_rec(536870912, 64'h8000_0000_0000_0000, '1, 1, 1, 2);
    keys = '{MODE_TOTAL, MODE_ID, MODE_NAME};
    src_gap_max  = 9;
    sink_gap_max = 9;
    foreach (keys[k]) begin
      set_sort_mode(keys[k]);
      foreach (tie_set[i]) send_record(tie_set[i], i == 5);
    end
  endtask

  task automatic test_overflow();
    set_sort_mode(MODE_TOTAL);
    src_gap_max  = 2;
    sink_gap_max = 9;
    for (int i = 0; i < Capacity; i++) send_record(rand_record(), 1'b0);
    // drop past capacity; the dropped last word still starts the sort
    send_record(rand_record(), 1'b0);
    send_record(rand_record(), 1'b0);
    send_record(rand_record(), 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    int set_len;
    sent = 0;
    foreach (name_pool[i]) name_pool[i] = make_name($urandom_range(16, 1));
    name_pool[1][63:0] = name_pool[0][63:0] ^ 64'h1;
    name_pool[1][127:64] = name_pool[0][127:64];
    while (sent < 92) begin
      if ($urandom_range(1, 0) == 1) set_sort_mode(sort_mode_t'($urandom_range(3, 0)));
      src_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 9;
      sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
      set_len = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int i = 0; i < set_len; i++) send_record(rand_record(), i == set_len - 1);
      sent += set_len;
    end
  endtask

  task automatic check_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ranked_row_t e;
    out_word_t   got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (ranked_rows.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time,
                 m_axis_tdata);
        fail_count++;
      end else begin
        e = ranked_rows.pop_front();
        check_field("position", 64'(e.w.position), 64'(got.position));
        check_field("out_id", 64'(e.w.student_id), 64'(got.student_id));
        check_field("out_name_head", e.w.name_head, got.name_head);
        check_field("out_name_tail", e.w.name_tail, got.name_tail);
        check_field("out_score_a", 64'(e.w.score_a), 64'(got.score_a));
        check_field("out_score_b", 64'(e.w.score_b), 64'(got.score_b));
        check_field("out_score_c", 64'(e.w.score_c), 64'(got.score_c));
        check_field("score_total", 64'(e.w.total), 64'(got.total));
        check_field("score_average", 64'(e.w.avg), 64'(got.avg));
        check_field("emit_last", 64'(e.last), 64'(m_axis_tlast));
      end
    end
  end

  // Result sink: draw a stall per word, then hold ready until a word moves.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = $urandom_range(sink_gap_max, 0);
      repeat (stall) @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid === 1'b1));
      @(negedge clk);
      m_axis_tready = 1'b0;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("record_sort_multi_key_core test failed");
    $finish;
  end

  initial begin : run_tests
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = MODE_NONE;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    roster_count  = 0;
    active_key    = MODE_NONE;
    fail_count    = 0;
    src_gap_max   = 0;
    sink_gap_max  = 0;
    foreach (name_pool[i]) name_pool[i] = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_keep_order();
    test_each_key();
    test_overflow();
    test_random_sets();

    while (ranked_rows.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("record_sort_multi_key_core test passed");
    end else begin
      $display("record_sort_multi_key_core test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rsmk_pkg.sv
rtl/core/rsmk_rec_mem.sv
rtl/core/rsmk_order.sv
rtl/core/record_sort_multi_key_core.sv
verif/tb_top.sv
